>>> hdl/ges_pkg.sv
// Package with the shared types, state codes and fixed-point helpers of the solver.
package ges_pkg;

	localparam logic [63:0] POS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] NEG_MAX = 64'h8000_0000_0000_0000;
	localparam logic [3:0]  ORDER_RESET = 4'd8;

	typedef struct packed {
		logic [63:0] value;
		logic        ovf;
	} fx_res_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_CP_RD,
		ST_CP_WR,
		ST_EL_RD,
		ST_EL_DIV,
		ST_EL_DIVW,
		ST_EL_RRD,
		ST_EL_MUL,
		ST_EL_MULW,
		ST_BS_ACC_RD,
		ST_BS_ACC,
		ST_BS_RD,
		ST_BS_MUL,
		ST_BS_MULW,
		ST_BS_PRD,
		ST_BS_DIV,
		ST_BS_DIVW,
		ST_OUT
	} ges_state_t;

	// Two's-complement magnitude; the most negative value maps to 2^63.
	function automatic logic [63:0] fx_mag(input logic [63:0] x);
		return x[63] ? (64'd0 - x) : x;
	endfunction

	// Applies a sign to a 128-bit magnitude and saturates to 64 bits.
	function automatic fx_res_t fx_sat(input logic neg, input logic [127:0] m);
		fx_res_t r;
		r.ovf = 1'b0;
		if (!neg) begin
			if (|m[127:63]) begin
				r.value = POS_MAX;
				r.ovf   = 1'b1;
			end else begin
				r.value = m[63:0];
			end
		end else begin
			if ((|m[127:64]) || (m[63:0] > NEG_MAX)) begin
				r.value = NEG_MAX;
				r.ovf   = 1'b1;
			end else begin
				r.value = 64'd0 - m[63:0];
			end
		end
		return r;
	endfunction

	// Saturating difference a - b.
	function automatic fx_res_t fx_sub(input logic [63:0] a, input logic [63:0] b);
		fx_res_t     r;
		logic [63:0] d;
		d     = a - b;
		r.ovf = ((a[63] ^ b[63]) & (a[63] ^ d[63]));
		if (r.ovf) begin
			r.value = a[63] ? NEG_MAX : POS_MAX;
		end else begin
			r.value = d;
		end
		return r;
	endfunction

endpackage

>>> hdl/ges_item_if.sv
// Interface of the input channel that carries one matrix or right-hand-side word.
interface ges_item_if;
	logic               valid;
	logic               ready;
	logic [2:0]         row;
	logic [2:0]         column;
	logic               is_rhs;
	logic signed [63:0] value;
	logic               start_solve;

	modport source (output valid, row, column, is_rhs, value, start_solve, input ready);
	modport sink (input valid, row, column, is_rhs, value, start_solve, output ready);
endinterface

>>> hdl/ges_result_if.sv
// Interface of the output channel that carries one solved unknown.
interface ges_result_if;
	logic               valid;
	logic               ready;
	logic [2:0]         index;
	logic signed [63:0] solution;
	logic               singular;
	logic               overflow;
	logic               last;

	modport source (output valid, index, solution, singular, overflow, last, input ready);
	modport sink (input valid, index, solution, singular, overflow, last, output ready);
endinterface

>>> hdl/ges_cfg_if.sv
// Interface of the configuration write channel for the order register.
interface ges_cfg_if;
	logic       valid;
	logic       ready;
	logic [3:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

>>> hdl/ges_mul.sv
// Iterative fixed-point multiplier built on one 32 by 32 partial-product multiplier.
module ges_mul #(
	parameter int FRAC_BITS = 48
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic        done,
	output logic [63:0] res,
	output logic        ovf
);
	import ges_pkg::*;

	logic         busy_q;
	logic [2:0]   step_q;
	logic         neg_q;
	logic [63:0]  ma_q;
	logic [63:0]  mb_q;
	logic [127:0] acc_q;
	logic         done_q;
	logic [63:0]  res_q;
	logic         ovf_q;

	logic [31:0]  pa;
	logic [31:0]  pb;
	logic [63:0]  prod;
	logic [127:0] prod_sh;
	logic [127:0] rnd_mag;
	fx_res_t      fin;

	// Step order: low*low, high*low, low*high, high*high.
	always_comb begin
		pa      = step_q[0] ? ma_q[63:32] : ma_q[31:0];
		pb      = step_q[1] ? mb_q[63:32] : mb_q[31:0];
		prod    = pa * pb;
		case (step_q)
			3'd0:    prod_sh = {64'd0, prod};
			3'd3:    prod_sh = {prod, 64'd0};
			default: prod_sh = {32'd0, prod, 32'd0};
		endcase
		// Truncation toward minus infinity: negative results round up in magnitude.
		rnd_mag = (acc_q >> FRAC_BITS)
			+ {127'd0, (neg_q && (|acc_q[FRAC_BITS-1:0]))};
		fin     = fx_sat(neg_q, rnd_mag);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				if (step_q == 3'd4) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q + 3'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= a[63] ^ b[63];
			ma_q  <= fx_mag(a);
			mb_q  <= fx_mag(b);
			acc_q <= '0;
		end else if (busy_q) begin
			if (step_q == 3'd4) begin
				res_q <= fin.value;
				ovf_q <= fin.ovf;
			end else begin
				acc_q <= acc_q + prod_sh;
			end
		end
	end

	assign done = done_q;
	assign res  = res_q;
	assign ovf  = ovf_q;
endmodule

>>> hdl/ges_div.sv
// Restoring fixed-point divider that retires one quotient bit per cycle.
module ges_div #(
	parameter int FRAC_BITS = 48
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic        done,
	output logic [63:0] res,
	output logic        ovf,
	output logic        sing
);
	import ges_pkg::*;

	logic         busy_q;
	logic         fin_q;
	logic [6:0]   cnt_q;
	logic         neg_q;
	logic [127:0] num_q;
	logic [63:0]  den_q;
	logic [63:0]  rem_q;
	logic [127:0] quo_q;
	logic         done_q;
	logic [63:0]  res_q;
	logic         ovf_q;
	logic         sing_q;

	logic [64:0]  rem_ext;
	logic         ge;
	logic [64:0]  rem_dif;
	fx_res_t      sat;

	always_comb begin
		rem_ext = {rem_q, num_q[127]};
		ge      = (rem_ext >= {1'b0, den_q});
		rem_dif = rem_ext - {1'b0, den_q};
		sat     = fx_sat(neg_q, quo_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			fin_q  <= 1'b0;
			if (start) begin
				if (b == 64'd0) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					cnt_q  <= 7'd127;
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd0) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end else if (fin_q) begin
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= a[63] ^ b[63];
			num_q <= {64'd0, fx_mag(a)} << FRAC_BITS;
			den_q <= fx_mag(b);
			rem_q <= '0;
			quo_q <= '0;
			if (b == 64'd0) begin
				// A zero divisor yields a zero quotient and marks the system singular.
				res_q  <= '0;
				ovf_q  <= 1'b0;
				sing_q <= 1'b1;
			end
		end else if (busy_q) begin
			num_q <= {num_q[126:0], 1'b0};
			quo_q <= {quo_q[126:0], ge};
			rem_q <= ge ? rem_dif[63:0] : rem_ext[63:0];
		end else if (fin_q) begin
			res_q  <= sat.value;
			ovf_q  <= sat.ovf;
			sing_q <= 1'b0;
		end
	end

	assign done = done_q;
	assign res  = res_q;
	assign ovf  = ovf_q;
	assign sing = sing_q;
endmodule

>>> hdl/gauss_elimination_solver.sv
// Top level of the dense linear-system solver with its sequencer and entry stores.
//
// Each accepted input word writes one entry of A or b in signed fixed point with
// FRAC_BITS fraction bits. A word with start_solve set writes its entry and then
// solves the system of the configured order n, during which the input channel is
// not ready. The solve first copies A and b into a working memory, then runs
// forward elimination without pivoting and back substitution on one shared
// multiplier and one shared bit-serial divider; the divider sets most of the solve
// length. Then n solution words are sent, index 0 first, each carrying the
// singular and overflow flags of the whole solve and last on the final one.
// The order register may only be written while the block is idle.
module gauss_elimination_solver #(
	parameter int MAX_ORDER = 8,
	parameter int FRAC_BITS = 48
) (
	input logic         clk,
	input logic         arst_n,
	ges_item_if.sink    items,
	ges_result_if.source results,
	ges_cfg_if.sink     cfg
);
	import ges_pkg::*;

	localparam int IW     = $clog2(MAX_ORDER + 1);
	localparam int XW     = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
	localparam int CDEPTH = MAX_ORDER * MAX_ORDER;
	localparam int AAW    = (CDEPTH > 1) ? $clog2(CDEPTH) : 1;
	localparam int WDEPTH = MAX_ORDER * (MAX_ORDER + 1);
	localparam int WAW    = $clog2(WDEPTH);

	ges_state_t state_q;
	ges_state_t state_d;

	logic [3:0]    order_q;
	logic [IW-1:0] n_q;
	logic [IW-1:0] i_q;
	logic [IW-1:0] j_q;
	logic [IW-1:0] r_q;
	logic [IW-1:0] k_q;
	logic [63:0]   l_q;
	logic [63:0]   acc_q;
	logic          sing_q;
	logic          ovf_q;

	// Entry stores. The working memory holds the rhs of each row in column n, after its coefficients.
	logic [63:0] coef_mem [CDEPTH];
	logic [63:0] work_mem [WDEPTH];
	logic [63:0] rhs_q [MAX_ORDER];
	logic [63:0] sol_q [MAX_ORDER];
	logic [63:0] coef_rd_q;
	logic [63:0] rda_q;
	logic [63:0] rdb_q;

	logic           item_acc;
	logic           coef_re;
	logic [AAW-1:0] coef_ra;
	logic           wa_re;
	logic           wb_re;
	logic [WAW-1:0] wa_addr;
	logic [WAW-1:0] wb_addr;
	logic           w_we;
	logic [WAW-1:0] w_waddr;
	logic [63:0]    w_wdata;
	logic           mul_start;
	logic [63:0]    mul_a;
	logic [63:0]    mul_b;
	logic           mul_done;
	logic [63:0]    mul_res;
	logic           mul_ovf;
	logic           div_start;
	logic [63:0]    div_a;
	logic [63:0]    div_b;
	logic           div_done;
	logic [63:0]    div_res;
	logic           div_ovf;
	logic           div_sing;
	logic [IW-1:0]  n_clamp;
	fx_res_t        el_diff;
	fx_res_t        bs_diff;

	function automatic logic [WAW-1:0] waddr(input logic [IW-1:0] ri, input logic [IW-1:0] ci);
		return WAW'(int'(ri) * (MAX_ORDER + 1) + int'(ci));
	endfunction

	ges_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.res    (mul_res),
		.ovf    (mul_ovf)
	);

	ges_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.a      (div_a),
		.b      (div_b),
		.done   (div_done),
		.res    (div_res),
		.ovf    (div_ovf),
		.sing   (div_sing)
	);

	assign item_acc  = items.valid && items.ready;
	assign cfg.ready = 1'b1;
	assign el_diff   = fx_sub(rda_q, mul_res);
	assign bs_diff   = fx_sub(acc_q, mul_res);

	// Order zero acts as one, and orders above the store size act as the maximum.
	always_comb begin
		if (order_q == 4'd0) begin
			n_clamp = IW'(1);
		end else if (int'(order_q) > MAX_ORDER) begin
			n_clamp = IW'(MAX_ORDER);
		end else begin
			n_clamp = IW'(order_q);
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (item_acc && items.start_solve) state_d = ST_CP_RD;
			end
			ST_CP_RD: state_d = ST_CP_WR;
			ST_CP_WR: begin
				if (j_q == n_q && int'(i_q) + 1 == int'(n_q)) begin
					state_d = (n_q == IW'(1)) ? ST_BS_ACC_RD : ST_EL_RD;
				end else begin
					state_d = ST_CP_RD;
				end
			end
			ST_EL_RD:  state_d = ST_EL_DIV;
			ST_EL_DIV: state_d = ST_EL_DIVW;
			ST_EL_DIVW: begin
				if (div_done) state_d = ST_EL_RRD;
			end
			ST_EL_RRD: state_d = ST_EL_MUL;
			ST_EL_MUL: state_d = ST_EL_MULW;
			ST_EL_MULW: begin
				if (mul_done) begin
					if (j_q != r_q) begin
						state_d = ST_EL_RRD;
					end else if (int'(i_q) != int'(r_q) + 1) begin
						state_d = ST_EL_RD;
					end else if (int'(r_q) + 3 <= int'(n_q)) begin
						state_d = ST_EL_RD;
					end else begin
						state_d = ST_BS_ACC_RD;
					end
				end
			end
			ST_BS_ACC_RD: state_d = ST_BS_ACC;
			ST_BS_ACC: begin
				state_d = (int'(i_q) + 1 < int'(n_q)) ? ST_BS_RD : ST_BS_PRD;
			end
			ST_BS_RD:  state_d = ST_BS_MUL;
			ST_BS_MUL: state_d = ST_BS_MULW;
			ST_BS_MULW: begin
				if (mul_done) begin
					state_d = (int'(j_q) == int'(i_q) + 1) ? ST_BS_PRD : ST_BS_RD;
				end
			end
			ST_BS_PRD: state_d = ST_BS_DIV;
			ST_BS_DIV: state_d = ST_BS_DIVW;
			ST_BS_DIVW: begin
				if (div_done) state_d = (i_q == '0) ? ST_OUT : ST_BS_ACC_RD;
			end
			ST_OUT: begin
				if (results.valid && results.ready && int'(k_q) + 1 == int'(n_q)) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		items.ready   = 1'b0;
		results.valid = 1'b0;
		coef_re       = 1'b0;
		coef_ra       = AAW'(int'(i_q) * MAX_ORDER + int'(j_q));
		wa_re         = 1'b0;
		wb_re         = 1'b0;
		wa_addr       = waddr(i_q, j_q);
		wb_addr       = waddr(r_q, j_q);
		w_we          = 1'b0;
		w_waddr       = waddr(i_q, j_q);
		w_wdata       = el_diff.value;
		mul_start     = 1'b0;
		mul_a         = l_q;
		mul_b         = rdb_q;
		div_start     = 1'b0;
		div_a         = rda_q;
		div_b         = rdb_q;
		unique case (state_q)
			ST_IDLE: items.ready = 1'b1;
			ST_CP_RD: coef_re = (j_q != n_q);
			ST_CP_WR: begin
				w_we    = 1'b1;
				w_wdata = (j_q == n_q) ? rhs_q[i_q[XW-1:0]] : coef_rd_q;
			end
			ST_EL_RD: begin
				wa_re   = 1'b1;
				wb_re   = 1'b1;
				wa_addr = waddr(i_q, r_q);
				wb_addr = waddr(r_q, r_q);
			end
			ST_EL_DIV: div_start = 1'b1;
			ST_EL_RRD: begin
				wa_re = 1'b1;
				wb_re = 1'b1;
			end
			ST_EL_MUL: mul_start = 1'b1;
			ST_EL_MULW: w_we = mul_done;
			ST_BS_ACC_RD: begin
				wa_re   = 1'b1;
				wa_addr = waddr(i_q, n_q);
			end
			ST_BS_RD: wa_re = 1'b1;
			ST_BS_MUL: begin
				mul_start = 1'b1;
				mul_a     = rda_q;
				mul_b     = sol_q[j_q[XW-1:0]];
			end
			ST_BS_PRD: begin
				wa_re   = 1'b1;
				wa_addr = waddr(i_q, i_q);
			end
			ST_BS_DIV: begin
				div_start = 1'b1;
				div_a     = acc_q;
				div_b     = rda_q;
			end
			ST_OUT: results.valid = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			order_q <= ORDER_RESET;
			n_q     <= IW'(1);
			i_q     <= '0;
			j_q     <= '0;
			r_q     <= '0;
			k_q     <= '0;
			sing_q  <= 1'b0;
			ovf_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg.valid && cfg.ready) order_q <= cfg.data;
			case (state_q)
				ST_IDLE: begin
					if (item_acc && items.start_solve) begin
						n_q    <= n_clamp;
						i_q    <= '0;
						j_q    <= '0;
						sing_q <= 1'b0;
						ovf_q  <= 1'b0;
					end
				end
				ST_CP_WR: begin
					if (j_q == n_q) begin
						j_q <= '0;
						if (int'(i_q) + 1 == int'(n_q)) begin
							r_q <= '0;
						end else begin
							i_q <= i_q + IW'(1);
						end
					end else begin
						j_q <= j_q + IW'(1);
					end
				end
				ST_EL_DIVW: begin
					if (div_done) begin
						sing_q <= sing_q | div_sing;
						ovf_q  <= ovf_q | div_ovf;
						j_q    <= n_q;
					end
				end
				ST_EL_MULW: begin
					if (mul_done) begin
						ovf_q <= ovf_q | mul_ovf | el_diff.ovf;
						if (j_q != r_q) begin
							j_q <= j_q - IW'(1);
						end else if (int'(i_q) == int'(r_q) + 1) begin
							r_q <= r_q + IW'(1);
							i_q <= n_q - IW'(1);
						end else begin
							i_q <= i_q - IW'(1);
						end
					end
				end
				ST_BS_ACC: j_q <= n_q - IW'(1);
				ST_BS_MULW: begin
					if (mul_done) begin
						ovf_q <= ovf_q | mul_ovf | bs_diff.ovf;
						j_q   <= j_q - IW'(1);
					end
				end
				ST_BS_DIVW: begin
					if (div_done) begin
						sing_q <= sing_q | div_sing;
						ovf_q  <= ovf_q | div_ovf;
						if (i_q == '0) begin
							k_q <= '0;
						end else begin
							i_q <= i_q - IW'(1);
						end
					end
				end
				ST_OUT: begin
					if (results.valid && results.ready) k_q <= k_q + IW'(1);
				end
				default: ;
			endcase
		end
	end

	// Payload registers and stores.
	always_ff @(posedge clk) begin
		if (item_acc && int'(items.row) < MAX_ORDER) begin
			if (items.is_rhs) begin
				rhs_q[XW'(items.row)] <= items.value;
			end else if (int'(items.column) < MAX_ORDER) begin
				coef_mem[AAW'(int'(items.row) * MAX_ORDER + int'(items.column))] <= items.value;
			end
		end
		if (coef_re) coef_rd_q <= coef_mem[coef_ra];
		if (w_we) work_mem[w_waddr] <= w_wdata;
		if (wa_re) rda_q <= work_mem[wa_addr];
		if (wb_re) rdb_q <= work_mem[wb_addr];
		if (state_q == ST_EL_DIVW && div_done) l_q <= div_res;
		if (state_q == ST_BS_ACC) acc_q <= rda_q;
		if (state_q == ST_BS_MULW && mul_done) acc_q <= bs_diff.value;
		if (state_q == ST_BS_DIVW && div_done) sol_q[i_q[XW-1:0]] <= div_res;
	end

	assign results.index    = 3'(k_q);
	assign results.solution = sol_q[k_q[XW-1:0]];
	assign results.singular = sing_q;
	assign results.overflow = ovf_q;
	assign results.last     = (int'(k_q) + 1 == int'(n_q));

	// The input side is never open while a solution word is on offer.
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid |-> !items.ready)
		else $error("input ready while results pending");

	// The final solution word returns the block to idle.
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && results.ready && results.last) |=> items.ready)
		else $error("block not idle after last word");

	// Only unknowns of the current system are sent.
	a_index: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid |-> (k_q < n_q))
		else $error("solution index beyond order");

	// The shared units are never started together.
	a_one_unit: assert property (@(posedge clk) disable iff (!arst_n)
		!(mul_start && div_start))
		else $error("multiplier and divider started together");
endmodule

>>> tb/ges_checker.sv
// Checker that predicts the solver's solution words and compares them with the output channel.
`timescale 1ns / 100ps
module ges_checker #(
	parameter int FRAC_BITS = 48
) (
	input  logic  clk,
	input  logic  arst_n,
	ges_item_if   items,
	ges_result_if results,
	ges_cfg_if    cfg,
	output int    errors,
	output int    pending
);
	import ges_pkg::POS_MAX;
	import ges_pkg::NEG_MAX;

	typedef struct packed {
		logic [2:0]  index;
		logic [63:0] solution;
		logic        singular;
		logic        overflow;
		logic        last;
	} solved_word_t;

	logic [63:0]  coef_mem [8][8];
	logic [63:0]  rhs_mem [8];
	logic [3:0]   order_reg;
	bit           zero_pivot_seen;
	bit           saturation_seen;
	solved_word_t solution_queue [$];

	function automatic logic [63:0] abs_of(input logic [63:0] x);
		return x[63] ? (64'd0 - x) : x;
	endfunction

	function automatic logic [63:0] clamp_signed(input logic neg, input logic [127:0] q);
		if (!neg) begin
			if (|q[127:63]) begin
				saturation_seen = 1'b1;
				return POS_MAX;
			end
			return q[63:0];
		end
		if ((|q[127:64]) || (q[63:0] > NEG_MAX)) begin
			saturation_seen = 1'b1;
			return NEG_MAX;
		end
		return 64'd0 - q[63:0];
	endfunction

	function automatic logic [63:0] diff_sat(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] d;
		d = a - b;
		if ((a[63] ^ b[63]) && (a[63] ^ d[63])) begin
			saturation_seen = 1'b1;
			return a[63] ? NEG_MAX : POS_MAX;
		end
		return d;
	endfunction

	// Product with the low fraction bits dropped, which floors the signed result.
	function automatic logic [63:0] prod_sat(input logic [63:0] a, input logic [63:0] b);
		logic         neg;
		logic [127:0] p;
		logic [127:0] q;
		neg = a[63] ^ b[63];
		p   = {64'd0, abs_of(a)} * {64'd0, abs_of(b)};
		q   = p >> FRAC_BITS;
		if (neg && (|(p & ((128'd1 << FRAC_BITS) - 128'd1))))
			q = q + 128'd1;
		return clamp_signed(neg, q);
	endfunction

	// Quotient of magnitudes truncates, so the signed result rounds toward zero.
	function automatic logic [63:0] quot_sat(input logic [63:0] a, input logic [63:0] b);
		logic         neg;
		logic [127:0] q;
		neg = a[63] ^ b[63];
		if (abs_of(b) == 64'd0) begin
			zero_pivot_seen = 1'b1;
			return 64'd0;
		end
		q = ({64'd0, abs_of(a)} << FRAC_BITS) / {64'd0, abs_of(b)};
		return clamp_signed(neg, q);
	endfunction

	function automatic void solve_system();
		logic [63:0]  m [8][8];
		logic [63:0]  v [8];
		logic [63:0]  x [8];
		logic [63:0]  l;
		logic [63:0]  acc;
		int           n;
		solved_word_t w;
		n = (order_reg == 4'd0) ? 1 : ((order_reg > 4'd8) ? 8 : int'(order_reg));
		zero_pivot_seen = 1'b0;
		saturation_seen = 1'b0;
		for (int i = 0; i < n; i++) begin
			for (int j = 0; j < n; j++)
				m[i][j] = coef_mem[i][j];
			v[i] = rhs_mem[i];
		end
		for (int r = 0; r < n; r++) begin
			for (int i = n - 1; i > r; i--) begin
				l = quot_sat(m[i][r], m[r][r]);
				for (int j = n - 1; j >= r; j--)
					m[i][j] = diff_sat(m[i][j], prod_sat(l, m[r][j]));
				v[i] = diff_sat(v[i], prod_sat(l, v[r]));
			end
		end
		for (int i = n - 1; i >= 0; i--) begin
			acc = v[i];
			for (int j = n - 1; j > i; j--)
				acc = diff_sat(acc, prod_sat(m[i][j], x[j]));
			x[i] = quot_sat(acc, m[i][i]);
		end
		for (int k = 0; k < n; k++) begin
			w.index    = 3'(k);
			w.solution = x[k];
			w.singular = zero_pivot_seen;
			w.overflow = saturation_seen;
			w.last     = (k == n - 1);
			solution_queue.push_back(w);
		end
	endfunction

	task automatic compare_field(input string name, input logic [63:0] e, input logic [63:0] a);
		if (e !== a) begin
			errors++;
			$display("%0t: %s mismatch, expected %h actual %h", $time, name, e, a);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		solved_word_t w;
		if (!arst_n) begin
			order_reg = ges_pkg::ORDER_RESET;
			solution_queue.delete();
			errors = 0;
		end else begin
			if (cfg.valid && cfg.ready)
				order_reg = cfg.data;
			if (results.valid && results.ready) begin
				if (solution_queue.size() == 0) begin
					errors++;
					$display("%0t: unexpected solution word, expected none actual index %0d value %h",
						$time, results.index, results.solution);
				end else begin
					w = solution_queue.pop_front();
					compare_field("index", 64'(w.index), 64'(results.index));
					compare_field("solution", w.solution, results.solution);
					compare_field("singular", 64'(w.singular), 64'(results.singular));
					compare_field("overflow", 64'(w.overflow), 64'(results.overflow));
					compare_field("last", 64'(w.last), 64'(results.last));
				end
			end
			if (items.valid && items.ready) begin
				if (items.is_rhs)
					rhs_mem[items.row] = items.value;
				else
					coef_mem[items.row][items.column] = items.value;
				if (items.start_solve)
					solve_system();
			end
		end
		pending = solution_queue.size();
	end
endmodule

>>> tb/tb.sv
// Top of the solver testbench: clock, reset, stimulus, output stalls and the verdict.
`timescale 1ns / 100ps
module tb;
	import ges_pkg::POS_MAX;
	import ges_pkg::NEG_MAX;

	// One in Q16.48.
	localparam logic [63:0] FX_ONE = 64'h0001_0000_0000_0000;

	logic clk;
	logic arst_n;
	int   errors;
	int   pending;

	ges_item_if   items ();
	ges_result_if results ();
	ges_cfg_if    cfg ();

	gauss_elimination_solver u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.items  (items),
		.results(results),
		.cfg    (cfg)
	);

	// The checker sees the same three channels and owns all prediction.
	ges_checker u_checker (
		.clk    (clk),
		.arst_n (arst_n),
		.items  (items),
		.results(results),
		.cfg    (cfg),
		.errors (errors),
		.pending(pending)
	);

	int words_sent;
	int words_due;
	int words_seen;
	int active_order;
	bit send_burst;
	bit rx_burst;
	bit long_hold_req;
	// Which entries have been loaded, so that a solve never reads one that was not.
	bit a_loaded [8][8];
	bit b_loaded [8];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
	end

	// A generous ceiling: several times the slowest legal run.
	initial begin
		#200_000_000;
		$display("simulation failed");
		$finish;
	end

	// Count delivered solution words; nonblocking so the stimulus reads a stable count.
	always @(posedge clk) begin
		if (arst_n && results.valid && results.ready)
			words_seen <= words_seen + 1;
	end

	// Receiver: random stalls per word, quiet stretches, and one long hold-off on request.
	initial begin
		int stall;
		results.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (long_hold_req) begin
				results.ready <= 1'b0;
				repeat (3000) @(posedge clk);
				long_hold_req = 1'b0;
			end
			if ($urandom_range(0, 31) == 0)
				rx_burst = !rx_burst;
			stall = rx_burst ? 0 : $urandom_range(0, 18);
			if (stall > 0) begin
				results.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			results.ready <= 1'b1;
			@(posedge clk);
			while (!results.valid) @(posedge clk);
		end
	end

	// Offers one word and waits for the handshake, then idles for a random gap.
	// With no gap the valid simply stays high for the next word.
	task automatic send_word(input logic [2:0] r, input logic [2:0] c, input logic rhs,
		input logic [63:0] v, input logic st);
		int gap;
		items.valid       <= 1'b1;
		items.row         <= r;
		items.column      <= c;
		items.is_rhs      <= rhs;
		items.value       <= v;
		items.start_solve <= st;
		@(posedge clk);
		while (!items.ready) @(posedge clk);
		words_sent++;
		if (rhs)
			b_loaded[r] = 1'b1;
		else
			a_loaded[r][c] = 1'b1;
		if (st)
			words_due += active_order;
		if ($urandom_range(0, 23) == 0)
			send_burst = !send_burst;
		gap = send_burst ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			items.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Holds off until every predicted word has come back, then lets the block settle.
	task automatic drain();
		items.valid <= 1'b0;
		@(posedge clk);
		while (words_seen != words_due) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_order(input logic [3:0] o);
		cfg.valid <= 1'b1;
		cfg.data  <= o;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		cfg.valid <= 1'b0;
		active_order = (o == 4'd0) ? 1 : ((o > 4'd8) ? 8 : int'(o));
	endtask

	// Mostly moderate values, with zeros, extremes and full-range noise mixed in.
	// Diagonal entries are usually pushed away from zero so most systems are well posed.
	function automatic logic [63:0] entry_value(input bit diag);
		int          k;
		logic [63:0] v;
		k = $urandom_range(0, 99);
		v = {$urandom, $urandom};
		if (k < 4)
			return 64'd0;
		if (k < 10) begin
			case ($urandom_range(0, 4))
				0: return POS_MAX;
				1: return NEG_MAX;
				2: return 64'd1;
				3: return '1;
				default: return FX_ONE;
			endcase
		end
		if (k < 20)
			return v;
		v = {{14{v[49]}}, v[49:0]};
		if (diag)
			v = v[63] ? v - 64'(active_order) * (FX_ONE << 2)
				: v + 64'(active_order) * (FX_ONE << 2);
		return v;
	endfunction

	// One load of the system in use: every entry not yet loaded, a random share of the
	// rest, some stray words anywhere in the stores, and a final word that starts the solve.
	task automatic load_and_solve();
		int       n;
		int       r;
		int       c;
		n = active_order;
		for (int i = 0; i < n; i++) begin
			for (int j = 0; j <= n; j++) begin
				if (j == n) begin
					if (!b_loaded[i] || $urandom_range(0, 2) == 0)
						send_word(3'(i), 3'($urandom), 1'b1, entry_value(1'b0), 1'b0);
				end else if (!a_loaded[i][j] || $urandom_range(0, 2) == 0) begin
					send_word(3'(i), 3'(j), 1'b0, entry_value(i == j), 1'b0);
				end
				if ($urandom_range(0, 9) == 0)
					send_word(3'($urandom), 3'($urandom), 1'($urandom), entry_value(1'b0), 1'b0);
			end
		end
		if ($urandom_range(0, 7) == 0) begin
			send_word(3'($urandom), 3'($urandom), 1'($urandom), {$urandom, $urandom}, 1'b1);
		end else begin
			r = $urandom_range(0, n - 1);
			c = $urandom_range(0, n);
			if (c == n)
				send_word(3'(r), 3'($urandom), 1'b1, entry_value(1'b0), 1'b1);
			else
				send_word(3'(r), 3'(c), 1'b0, entry_value(r == c), 1'b1);
		end
	endtask

	initial begin
		logic [3:0] o;
		int         phase;
		int         pick;
		logic [3:0] first_orders [3];
		first_orders = '{4'd0, 4'd15, 4'd8};
		items.valid       <= 1'b0;
		items.row         <= '0;
		items.column      <= '0;
		items.is_rhs      <= 1'b0;
		items.value       <= '0;
		items.start_solve <= 1'b0;
		cfg.valid         <= 1'b0;
		cfg.data          <= '0;
		words_sent    = 0;
		words_due     = 0;
		words_seen    = 0;
		send_burst    = 1'b0;
		rx_burst      = 1'b0;
		long_hold_req = 1'b0;
		active_order  = 8;
		@(posedge arst_n);
		@(posedge clk);

		// Order one: exact extremes, a zero pivot, a tiny pivot that overflows,
		// the most negative pivot, and ordinary signed values.
		write_order(4'd1);
		send_word(3'd0, 3'd0, 1'b0, FX_ONE, 1'b0);
		send_word(3'd0, 3'd5, 1'b1, POS_MAX, 1'b1);
		send_word(3'd0, 3'd0, 1'b1, NEG_MAX, 1'b1);
		send_word(3'd0, 3'd0, 1'b0, 64'd0, 1'b1);
		send_word(3'd0, 3'd0, 1'b0, 64'd1, 1'b0);
		send_word(3'd0, 3'd7, 1'b1, POS_MAX, 1'b1);
		send_word(3'd0, 3'd0, 1'b0, NEG_MAX, 1'b0);
		send_word(3'd0, 3'd0, 1'b1, '1, 1'b1);
		send_word(3'd0, 3'd0, 1'b0, 64'd0 - (FX_ONE << 1), 1'b0);
		send_word(3'd0, 3'd0, 1'b1, 3 * FX_ONE, 1'b1);
		drain();

		// Order two: a zero leading pivot met during elimination, then a regular
		// system, then products that saturate; stray writes land beyond the order.
		write_order(4'd2);
		send_word(3'd0, 3'd0, 1'b0, 64'd0, 1'b0);
		send_word(3'd0, 3'd1, 1'b0, FX_ONE, 1'b0);
		send_word(3'd1, 3'd0, 1'b0, FX_ONE, 1'b0);
		send_word(3'd1, 3'd1, 1'b0, FX_ONE, 1'b0);
		send_word(3'd0, 3'd0, 1'b1, FX_ONE, 1'b0);
		send_word(3'd7, 3'd7, 1'b0, POS_MAX, 1'b0);
		send_word(3'd1, 3'd0, 1'b1, FX_ONE << 1, 1'b1);
		send_word(3'd0, 3'd0, 1'b0, FX_ONE << 1, 1'b1);
		send_word(3'd0, 3'd1, 1'b0, POS_MAX, 1'b0);
		send_word(3'd1, 3'd0, 1'b0, NEG_MAX, 1'b0);
		send_word(3'd7, 3'd3, 1'b1, NEG_MAX, 1'b0);
		send_word(3'd1, 3'd1, 1'b0, 64'd1, 1'b1);
		drain();

		// Random phases: the out-of-range and full orders first, then mostly small
		// systems. One phase asks the receiver for a long hold-off so the block backs up.
		phase = 0;
		while (words_sent < 450) begin
			if (phase < 3) begin
				o = first_orders[phase];
			end else begin
				pick = $urandom_range(0, 9);
				o = (pick < 6) ? 4'($urandom_range(1, 4))
					: ((pick < 9) ? 4'($urandom_range(5, 7)) : 4'd8);
			end
			drain();
			write_order(o);
			if (phase == 4)
				long_hold_req = 1'b1;
			repeat ($urandom_range(2, 4)) load_and_solve();
			phase++;
		end

		drain();
		repeat (40) @(posedge clk);
		if (errors == 0 && pending == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule
